@@ rtl/i2a_pkg.sv @@
// Shared types, constants and small lookup functions for the integer-to-ASCII formatter.
// Used by i2a_divu and integer_to_ascii_formatter_core; depends on nothing else.
package i2a_pkg;

    // Sizes of the digit store and the saturation limit for width and digit count.
    localparam int DIGIT_BUFFER = 32;
    localparam int MAX_FIELD    = 60;
    localparam int CNT_W        = $clog2(DIGIT_BUFFER + 1);
    localparam int IDX_W        = $clog2(DIGIT_BUFFER);

    // Bit positions inside format_flags.
    localparam int F_LEFT   = 0;
    localparam int F_PLUS   = 1;
    localparam int F_SPACE  = 2;
    localparam int F_ALT    = 3;
    localparam int F_ZERO   = 4;
    localparam int F_SIGNED = 5;
    localparam int F_LOWER  = 6;

    // Base limits and the two bases that take a prefix.
    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    // ASCII codes.
    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // Result of one division step, passed from the divider to the sequencer.
    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [3:0]  rem;
    } div_res_t;

    // floor(2^32 / base); the product with it underestimates the quotient by at most one.
    function automatic logic [31:0] recip(input logic [4:0] base);
        logic [31:0] m;
        begin
            case (base)
                5'd2:    m = 32'h8000_0000;
                5'd3:    m = 32'h5555_5555;
                5'd4:    m = 32'h4000_0000;
                5'd5:    m = 32'h3333_3333;
                5'd6:    m = 32'h2AAA_AAAA;
                5'd7:    m = 32'h2492_4924;
                5'd8:    m = 32'h2000_0000;
                5'd9:    m = 32'h1C71_C71C;
                5'd10:   m = 32'h1999_9999;
                5'd11:   m = 32'h1745_D174;
                5'd12:   m = 32'h1555_5555;
                5'd13:   m = 32'h13B1_3B13;
                5'd14:   m = 32'h1249_2492;
                5'd15:   m = 32'h1111_1111;
                5'd16:   m = 32'h1000_0000;
                default: m = 32'h0000_0000;
            endcase
            return m;
        end
    endfunction

    // Maps a digit value to its ASCII character in the chosen case.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] ch;
        begin
            if (d < 4'd10) begin
                ch = CH_ZERO + {4'b0, d};
            end else if (lower) begin
                ch = CH_LO_A + {4'b0, d} - 8'd10;
            end else begin
                ch = CH_UP_A + {4'b0, d} - 8'd10;
            end
            return ch;
        end
    endfunction

    // Sign-extends a 7-bit count and clamps it at the field limit.
    function automatic logic signed [7:0] sat_field(input logic [6:0] f);
        logic signed [7:0] x;
        begin
            x = $signed({f[6], f});
            if (x > $signed(8'(MAX_FIELD))) begin
                x = $signed(8'(MAX_FIELD));
            end
            return x;
        end
    endfunction

endpackage

@@ rtl/integer_to_ascii_formatter_core.sv @@
// Top level of the printf-style integer formatter: sequencer, digit store and output register.
// Depends on i2a_pkg and instantiates i2a_divu.
//
// Usage: drive value, radix, format_flags, field_width and min_digits with start high;
// the item is taken at a clock edge where busy is low. busy stays high until the last
// character has been produced. Characters come out on text_char one per strobe of
// char_valid, most significant part first, and last_char marks the final one. The
// receiver cannot stall: each character is present for exactly one cycle.
// Steps: each digit passes through the shared reciprocal-multiply divider
// (multiply, correct, write back), then a setup state, then one character per cycle,
// except in states where a formatting phase emits nothing.
// The first character can be on the outputs in the cycle after the sequencer enters the
// leading-pad phase.
// A radix outside 2 to 16 is taken and produces no characters; busy stays low.
// Reset clears the sequencer and the output strobe; the block is idle afterward.
module integer_to_ascii_formatter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [4:0]  radix,
    input  logic [6:0]  format_flags,
    input  logic [6:0]  field_width,
    input  logic [6:0]  min_digits,
    output logic        char_valid,
    output logic [7:0]  text_char,
    output logic        last_char
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DIVGO   = 4'd1;
    localparam logic [3:0] ST_DIVWAIT = 4'd2;
    localparam logic [3:0] ST_SETUP   = 4'd3;
    localparam logic [3:0] ST_LEAD    = 4'd4;
    localparam logic [3:0] ST_SIGN    = 4'd5;
    localparam logic [3:0] ST_PFX0    = 4'd6;
    localparam logic [3:0] ST_PFXX    = 4'd7;
    localparam logic [3:0] ST_ZPAD    = 4'd8;
    localparam logic [3:0] ST_PREC    = 4'd9;
    localparam logic [3:0] ST_DIGIT   = 4'd10;
    localparam logic [3:0] ST_TRAIL   = 4'd11;

    localparam int CNT_W = i2a_pkg::CNT_W;
    localparam int IDX_W = i2a_pkg::IDX_W;

    logic [3:0]              state_reg, state_next;
    logic [31:0]             mag_reg, mag_next;
    logic [4:0]              base_reg, base_next;
    logic [6:0]              flags_reg, flags_next;
    logic                    nz_reg, nz_next;
    logic [7:0]              sign_reg, sign_next;
    logic signed [7:0]       wide_reg, wide_next;
    logic signed [7:0]       prec_reg, prec_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [3:0]              dig_reg [i2a_pkg::DIGIT_BUFFER];
    logic [3:0]              dig_rd_reg;
    logic                    valid_reg, valid_next;
    logic [7:0]              char_reg, char_next;
    logic                    last_reg, last_next;

    logic                    dig_we;
    logic [IDX_W-1:0]        dig_waddr;
    logic [3:0]              dig_wdata;
    logic [IDX_W-1:0]        dig_raddr;

    logic                    div_go;
    i2a_pkg::div_res_t       div_res;

    logic                    accept;
    logic                    radix_ok;
    logic                    neg_in;
    logic [31:0]             mag_in;
    logic [7:0]              sign_in;
    logic                    alt_in;
    logic                    hex_pfx_in;
    logic                    oct_alt_in;
    logic [7:0]              wide_adj;
    logic signed [7:0]       cnt_s;
    logic signed [7:0]       prec_max;
    logic                    left;
    logic                    wide_pos;
    logic                    alt_pfx;

    // Shared divide-by-base unit.
    i2a_divu u_divu (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (mag_reg),
        .radix    (base_reg),
        .res      (div_res)
    );

    // Decode of an incoming item: sign, magnitude and width adjustments.
    assign accept     = start && !busy;
    assign radix_ok   = (radix >= i2a_pkg::RADIX_MIN) && (radix <= i2a_pkg::RADIX_MAX);
    assign neg_in     = format_flags[i2a_pkg::F_SIGNED] && value[31];
    assign mag_in     = neg_in ? (32'd0 - value) : value;
    assign alt_in     = format_flags[i2a_pkg::F_ALT];
    assign hex_pfx_in = alt_in && (radix == i2a_pkg::RADIX_HEX) && (value != 32'd0);
    assign oct_alt_in = alt_in && (radix == i2a_pkg::RADIX_OCT);

    always_comb
    begin
        if (neg_in)
        begin
            sign_in = i2a_pkg::CH_MINUS;
        end
        else if (format_flags[i2a_pkg::F_PLUS])
        begin
            sign_in = i2a_pkg::CH_PLUS;
        end
        else if (format_flags[i2a_pkg::F_SPACE])
        begin
            sign_in = i2a_pkg::CH_SPACE;
        end
        else
        begin
            sign_in = i2a_pkg::CH_NONE;
        end
    end

    assign wide_adj = 8'(sign_in != i2a_pkg::CH_NONE) + (hex_pfx_in ? 8'd2 : 8'd0)
                    + 8'(oct_alt_in);

    // Helpers for the output phases.
    assign cnt_s     = $signed({{(8 - CNT_W){1'b0}}, cnt_reg});
    assign prec_max  = (prec_reg > cnt_s) ? prec_reg : cnt_s;
    assign left      = flags_reg[i2a_pkg::F_LEFT];
    assign wide_pos  = wide_reg > 8'sd0;
    assign alt_pfx   = flags_reg[i2a_pkg::F_ALT] && nz_reg;

    // The read address follows the next count, so the registered digit is ready in time.
    assign dig_raddr = IDX_W'(cnt_next - 1'b1);

    // Sequencer: digit extraction, then one formatting phase after another.
    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        base_next  = base_reg;
        flags_next = flags_reg;
        nz_next    = nz_reg;
        sign_next  = sign_reg;
        wide_next  = wide_reg;
        prec_next  = prec_reg;
        cnt_next   = cnt_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = 1'b0;
        dig_we     = 1'b0;
        dig_waddr  = cnt_reg[IDX_W-1:0];
        dig_wdata  = div_res.rem;
        div_go     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && radix_ok)
                begin
                    mag_next   = mag_in;
                    base_next  = radix;
                    flags_next = format_flags;
                    nz_next    = value != 32'd0;
                    sign_next  = sign_in;
                    wide_next  = i2a_pkg::sat_field(field_width) - $signed(wide_adj);
                    prec_next  = i2a_pkg::sat_field(min_digits)
                               - $signed(8'(oct_alt_in));
                    if (mag_in == 32'd0)
                    begin
                        // A zero value is the single digit zero.
                        dig_we     = 1'b1;
                        dig_waddr  = '0;
                        dig_wdata  = 4'd0;
                        cnt_next   = CNT_W'(1);
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_DIVGO;
                    end
                end
            end
            ST_DIVGO:
            begin
                div_go     = 1'b1;
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (div_res.done)
                begin
                    dig_we   = 1'b1;
                    mag_next = div_res.quot;
                    cnt_next = cnt_reg + 1'b1;
                    if ((div_res.quot == 32'd0)
                        || (cnt_reg == CNT_W'(i2a_pkg::DIGIT_BUFFER - 1)))
                    begin
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_DIVGO;
                    end
                end
            end
            ST_SETUP:
            begin
                prec_next  = prec_max;
                wide_next  = wide_reg - prec_max;
                state_next = ST_LEAD;
            end
            ST_LEAD:
            begin
                if (!left && !flags_reg[i2a_pkg::F_ZERO] && wide_pos)
                begin
                    valid_next = 1'b1;
                    char_next  = i2a_pkg::CH_SPACE;
                    wide_next  = wide_reg - 8'sd1;
                end
                else
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (sign_reg != i2a_pkg::CH_NONE)
                begin
                    valid_next = 1'b1;
                    char_next  = sign_reg;
                end
                state_next = ST_PFX0;
            end
            ST_PFX0:
            begin
                if (alt_pfx && ((base_reg == i2a_pkg::RADIX_OCT)
                                || (base_reg == i2a_pkg::RADIX_HEX)))
                begin
                    valid_next = 1'b1;
                    char_next  = i2a_pkg::CH_ZERO;
                end
                state_next = ST_PFXX;
            end
            ST_PFXX:
            begin
                if (alt_pfx && (base_reg == i2a_pkg::RADIX_HEX))
                begin
                    valid_next = 1'b1;
                    char_next  = flags_reg[i2a_pkg::F_LOWER] ? i2a_pkg::CH_LO_X
                                                              : i2a_pkg::CH_UP_X;
                end
                state_next = ST_ZPAD;
            end
            ST_ZPAD:
            begin
                if (!left && wide_pos)
                begin
                    valid_next = 1'b1;
                    char_next  = i2a_pkg::CH_ZERO;
                    wide_next  = wide_reg - 8'sd1;
                end
                else
                begin
                    state_next = ST_PREC;
                end
            end
            ST_PREC:
            begin
                if (prec_reg > cnt_s)
                begin
                    valid_next = 1'b1;
                    char_next  = i2a_pkg::CH_ZERO;
                    prec_next  = prec_reg - 8'sd1;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                // Digits were stored least significant first, so read them backward.
                valid_next = 1'b1;
                char_next  = i2a_pkg::digit_char(dig_rd_reg, flags_reg[i2a_pkg::F_LOWER]);
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    last_next  = !wide_pos;
                    state_next = wide_pos ? ST_TRAIL : ST_IDLE;
                end
            end
            ST_TRAIL:
            begin
                valid_next = 1'b1;
                char_next  = i2a_pkg::CH_SPACE;
                wide_next  = wide_reg - 8'sd1;
                if (wide_reg == 8'sd1)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        base_reg  <= base_next;
        flags_reg <= flags_next;
        nz_reg    <= nz_next;
        sign_reg  <= sign_next;
        wide_reg  <= wide_next;
        prec_reg  <= prec_next;
        cnt_reg   <= cnt_next;
        char_reg  <= char_next;
    end

    // Digit store, written one digit per division and read through a register.
    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            dig_reg[dig_waddr] <= dig_wdata;
        end
        dig_rd_reg <= dig_reg[dig_raddr];
    end

    assign busy       = state_reg != ST_IDLE;
    assign char_valid = valid_reg;
    assign text_char  = char_reg;
    assign last_char  = last_reg;

    // The last-character mark only comes with a character.
    a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> char_valid)
        else $error("last_char without char_valid");

    // After the final character no further character follows at once.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && last_char) |=> !char_valid)
        else $error("character directly after last_char");

    // An item with a valid base makes the block busy.
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (radix >= i2a_pkg::RADIX_MIN) && (radix <= i2a_pkg::RADIX_MAX))
        |=> busy)
        else $error("valid item accepted but block not busy");

    // The divider only reports a result while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_DIVWAIT))
        else $error("divider result outside wait phase");

endmodule

@@ rtl/i2a_divu.sv @@
// Shared divide-by-base unit: quotient and remainder of a 32-bit value by a base of 2 to 16.
// Uses a reciprocal multiply and one correction step; depends on i2a_pkg.
module i2a_divu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [31:0]        dividend,
    input  logic [4:0]         radix,
    output i2a_pkg::div_res_t  res
);

    logic        s1_valid_reg;
    logic [31:0] prod_hi_reg;
    logic [5:0]  num_lo_reg;
    logic [4:0]  base_reg;
    logic        done_reg;
    logic [31:0] quot_reg;
    logic [3:0]  rem_reg;

    logic [63:0] prod;
    logic [31:0] q0;
    logic [10:0] qb_full;
    logic [5:0]  r0;
    logic        fix;
    logic [5:0]  r_fixed;

    // Stage one: multiply by the reciprocal of the base.
    assign prod = dividend * i2a_pkg::recip(radix);

    // Stage two: remainder from the low bits only, since it is below twice the base.
    assign q0      = prod_hi_reg;
    assign qb_full = q0[5:0] * base_reg;
    assign r0      = num_lo_reg - qb_full[5:0];
    assign fix     = r0 >= {1'b0, base_reg};
    assign r_fixed = fix ? (r0 - {1'b0, base_reg}) : r0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= go;
            done_reg     <= s1_valid_reg;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_hi_reg <= prod[63:32];
            num_lo_reg  <= dividend[5:0];
            base_reg    <= radix;
        end
        if (s1_valid_reg)
        begin
            quot_reg <= fix ? (q0 + 32'd1) : q0;
            rem_reg  <= r_fixed[3:0];
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule
